// ===== rtl/core/mbp_pkg.sv =====
// mbp_pkg: shared types and constants of the multiply blend pixel block.
// No dependencies.
`default_nettype none
package mbp_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned PIXEL_W    = CHAN_W * NUM_CHAN;
  localparam int unsigned FACTOR_W   = CHAN_W + 1;
  localparam int unsigned PROD_W     = CHAN_W + FACTOR_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [FACTOR_W-1:0]   factor_t;
  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam factor_t  FACTOR_UNITY = factor_t'(1 << CHAN_W);
  localparam chan_t    CHAN_MAX     = '1;
  localparam chan_t    OPACITY_RST  = '1;

  localparam cfg_idx_t REG_OPACITY_ENABLE  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_OPACITY         = cfg_idx_t'(1);
  localparam cfg_idx_t REG_KEEP_DEST_ALPHA = cfg_idx_t'(2);

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/mbp_lane.sv =====
// mbp_lane: one byte channel of the multiply blend, two register stages.
// Depends on mbp_pkg.
`default_nettype none
module mbp_lane import mbp_pkg::*; (
  input  wire logic  clk,
  input  wire ctl_t  ctl,
  input  wire chan_t dest_byte,
  input  wire chan_t src_byte,
  input  wire logic  opacity_enable,
  input  wire chan_t opacity,
  input  wire logic  keep_dest,
  output chan_t      out_byte
);

  logic [2*CHAN_W-1:0] weight;
  chan_t               inv_src;
  factor_t             factor_nxt;
  factor_t             factor_r;
  chan_t               dest_r;
  logic [PROD_W-1:0]   prod;
  chan_t               out_byte_r;

  always_comb begin
    inv_src = CHAN_MAX - src_byte;
    weight  = inv_src * opacity;
    if (keep_dest) begin
      factor_nxt = FACTOR_UNITY;
    end else if (opacity_enable) begin
      factor_nxt = {1'b0, ~weight[2*CHAN_W-1:CHAN_W]};
    end else begin
      factor_nxt = {1'b0, src_byte};
    end
  end

  assign prod = dest_r * factor_r;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      factor_r <= factor_nxt;
      dest_r   <= dest_byte;
    end
    if (ctl.s2_en) begin
      out_byte_r <= prod[2*CHAN_W-1:CHAN_W];
    end
  end

  assign out_byte = out_byte_r;

endmodule
`default_nettype wire

// ===== rtl/core/mbp_flow.sv =====
// mbp_flow: valid/stall control of the two-stage pixel pipeline.
// Depends on mbp_pkg; drives the stage enables of all lanes.
`default_nettype none
module mbp_flow import mbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic last_in,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      last_out,
  output ctl_t      ctl
);

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic last1_r;
  logic last_out_r;
  logic s1_ready;
  logic s2_ready;

  always_comb begin
    s2_ready      = !out_valid_r || !out_stall;
    s1_ready      = !s1_valid_r || s2_ready;
    ctl.s1_en     = in_valid && s1_ready && rst_n;
    ctl.s2_en     = s1_valid_r && s2_ready;
    s1_valid_nxt  = ctl.s1_en ? 1'b1 : (ctl.s2_en ? 1'b0 : s1_valid_r);
    out_valid_nxt = ctl.s2_en ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      last1_r <= last_in;
    end
    if (ctl.s2_en) begin
      last_out_r <= last1_r;
    end
  end

  assign in_stall  = !s1_ready || !rst_n;
  assign out_valid = out_valid_r;
  assign last_out  = last_out_r;

endmodule
`default_nettype wire

// ===== rtl/core/multiply_blend_pixel.sv =====
// multiply_blend_pixel: multiply blend of an ARGB8888 source onto a destination pixel.
// Factor, then result register; throughput 1 beat per cycle unless the output stalls.
// Four byte lanes each hold one 8x8 factor multiply and one 8x9 blend multiply.
// A stall on the output holds both stages; input is taken while a stage is free.
// Reset (rst_n low, synchronous) empties the pipeline and restores opacity_enable=0,
// opacity=255, keep_dest_alpha=0; input is stalled while reset is held.
`default_nettype none
module multiply_blend_pixel import mbp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_data_t cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pixel_t    in_dest_pixel,
  input  wire pixel_t    in_src_pixel,
  input  wire logic      in_last_in,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pixel_t         out_blended_pixel,
  output logic           out_last_out
);

  logic  opacity_enable_r;
  chan_t opacity_r;
  logic  keep_dest_alpha_r;
  ctl_t  ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_enable_r  <= 1'b0;
      opacity_r         <= OPACITY_RST;
      keep_dest_alpha_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPACITY_ENABLE:  opacity_enable_r  <= cfg_wdata[0];
        REG_OPACITY:         opacity_r         <= cfg_wdata[CHAN_W-1:0];
        REG_KEEP_DEST_ALPHA: keep_dest_alpha_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mbp_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .last_in   (in_last_in),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last_out  (out_last_out),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
    mbp_lane u_lane (
      .clk            (clk),
      .ctl            (ctl),
      .dest_byte      (in_dest_pixel[i*CHAN_W +: CHAN_W]),
      .src_byte       (in_src_pixel[i*CHAN_W +: CHAN_W]),
      .opacity_enable (opacity_enable_r),
      .opacity        (opacity_r),
      .keep_dest      ((i == NUM_CHAN - 1) ? keep_dest_alpha_r : 1'b0),
      .out_byte       (out_blended_pixel[i*CHAN_W +: CHAN_W])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbp_checker.sv =====
// mbp_checker: port-level assertions for multiply_blend_pixel, bound to the top level.
// Depends on mbp_pkg.
`default_nettype none
module mbp_checker import mbp_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_valid,
  input wire logic   in_stall,
  input wire logic   out_valid,
  input wire logic   out_stall,
  input wire pixel_t out_blended_pixel,
  input wire logic   out_last_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_blended_pixel)
      && $stable(out_last_out))
    else $error("stalled result beat changed");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result beat without input beat two cycles earlier");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind multiply_blend_pixel mbp_checker u_mbp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_blended_pixel (out_blended_pixel),
  .out_last_out      (out_last_out)
);
`default_nettype wire
